FILE: design/gif_lzw_encoder_defines.svh
// assertion macros shared by the checker
`ifndef GIF_LZW_ENCODER_DEFINES_SVH
`define GIF_LZW_ENCODER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GLE_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gle check failed");

// antecedent implies consequent in the next cycle
`define GLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gle check failed");

`endif

FILE: design/gle_pkg.sv
`default_nettype none
package gle_pkg;
	localparam int MAX_WIDTH = 12;
	localparam int CODE_W    = 13;
	localparam int PREF_W    = 12;
	localparam int PIX_W     = 8;
	localparam int ACC_W     = 19;
	localparam int BITS_W    = 5;

	typedef struct packed {
		logic              used;
		logic [CODE_W-1:0] code;
		logic [PREF_W-1:0] prefix;
		logic [PIX_W-1:0]  pix;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

FILE: design/gle_ram.sv
`default_nettype none
module gle_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 5021
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: design/gle_probe.sv
`default_nettype none
module gle_probe #(
	parameter int DICT_SIZE = 5021
) (
	input  wire logic                            start,
	input  wire logic [gle_pkg::PIX_W-1:0]       pix,
	input  wire logic [gle_pkg::PREF_W-1:0]      prefix,
	input  wire logic [$clog2(DICT_SIZE)-1:0]    ind,
	input  wire logic [$clog2(DICT_SIZE):0]      stp,
	output logic      [$clog2(DICT_SIZE)-1:0]    idx,
	output logic      [$clog2(DICT_SIZE):0]      first_step
);
	localparam int IDX_W = $clog2(DICT_SIZE);

	logic [gle_pkg::PREF_W-1:0] hash;
	logic [IDX_W:0]             hash_x;
	logic [IDX_W:0]             ind_x;
	logic [IDX_W:0]             nxt;

	// hash stays below 4096, so with a DICT_SIZE of 4096 or more the modulo is a no-op
	assign hash   = {pix, 4'h0} ^ prefix;
	assign hash_x = (IDX_W+1)'(hash);
	assign ind_x  = {1'b0, ind};

	// the probe step is fixed by the first slot of the chain
	always_comb begin
		first_step = (hash == '0) ? (IDX_W+1)'(1) : (IDX_W+1)'(DICT_SIZE) - hash_x;
		if (ind_x >= stp) begin
			nxt = ind_x - stp;
		end else begin
			nxt = ind_x + (IDX_W+1)'(DICT_SIZE) - stp;
		end
		idx = start ? IDX_W'(hash) : nxt[IDX_W-1:0];
	end
endmodule
`default_nettype wire

FILE: design/gif_lzw_encoder.sv
`default_nettype none
// channel   | handshake             | payload
// ----------+-----------------------+------------------------------------
// pixel in  | in_valid / in_ready   | pixel, end_of_image
// bytes out | out_valid / out_ready | stream_byte, run_last, image_done
// config    | cfg_we                | cfg_wdata (min_code_size)
// each dictionary probe is S_PRB_RD then S_PRB_CMP; each code is S_SEND then S_PACK per byte
// a pixel that extends the string goes on to S_LASTCHK, a new string to S_MISS and S_MISS2
// the first pixel of an image and a table overflow sweep the dictionary in S_CLEAR,
// during which no pixel is taken
// arst_n clears control state but for ovf_q and free_q; the dictionary holds no reset
// a stalled output holds the sequencer only when a further byte must go out
module gif_lzw_encoder #(
	parameter int DICT_SIZE = 5021
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] pixel,
	input  wire logic       end_of_image,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] stream_byte,
	output logic            run_last,
	output logic            image_done,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata
);
	localparam int IDX_W = $clog2(DICT_SIZE);

	typedef enum logic [3:0] {
		S_IDLE, S_FIRST, S_PRB_RD, S_PRB_CMP, S_MISS, S_MISS2, S_OVF, S_CLEAR,
		S_LASTCHK, S_FL_END, S_FL_PAD, S_SEND, S_PACK, S_FINISH
	} state_t;

	state_t state_q, ret_q;

	logic [3:0]                     mcs_q;
	logic [3:0]                     root_q;
	logic [3:0]                     width_q;
	logic [gle_pkg::CODE_W-1:0]     nfc_q;
	logic [gle_pkg::PREF_W-1:0]     prefix_q;
	logic [gle_pkg::PREF_W-1:0]     code_q;
	logic [7:0]                     pix_q;
	logic                           last_q;
	logic                           in_image_q;
	logic                           free_q;
	logic                           ovf_q;
	logic [IDX_W-1:0]               ind_q;
	logic [IDX_W:0]                 step_q;
	logic [IDX_W-1:0]               k_q;
	logic [7:0]                     partial_q;
	logic [2:0]                     count_q;
	logic [gle_pkg::ACC_W-1:0]      acc_q;
	logic [gle_pkg::BITS_W-1:0]     bits_q;
	logic                           held_valid_q;
	logic [7:0]                     held_q;
	logic                           out_valid_q;
	logic [7:0]                     out_byte_q;
	logic                           out_last_q;
	logic                           out_done_q;

	logic                           out_free;
	logic                           can_push;
	logic                           emit_v;
	logic                           emit_last;
	logic                           emit_done;
	logic [7:0]                     pix_m;
	logic [3:0]                     root_new;
	logic [gle_pkg::CODE_W-1:0]     limit;
	logic [gle_pkg::CODE_W-1:0]     clr_code;
	logic [gle_pkg::PREF_W-1:0]     width_mask;
	logic                           ram_we;
	logic [IDX_W-1:0]               ram_waddr;
	gle_pkg::entry_t                ram_wdata;
	gle_pkg::entry_t                rd_entry;
	logic [gle_pkg::ENTRY_W-1:0]    ram_rdata;
	logic [IDX_W-1:0]               probe_idx;
	logic [IDX_W:0]                 probe_step;

	assign out_free    = !out_valid_q || out_ready;
	assign can_push    = !held_valid_q || out_free;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign stream_byte = out_byte_q;
	assign run_last    = out_last_q;
	assign image_done  = out_done_q;
	assign rd_entry    = gle_pkg::entry_t'(ram_rdata);

	always_comb begin
		logic [gle_pkg::CODE_W-1:0] m;
		m          = (gle_pkg::CODE_W'(1) << root_q) - gle_pkg::CODE_W'(1);
		pix_m      = pixel & m[7:0];
		limit      = gle_pkg::CODE_W'(1) << width_q;
		clr_code   = gle_pkg::CODE_W'(1) << root_q;
		width_mask = gle_pkg::PREF_W'(limit - gle_pkg::CODE_W'(1));
		if (mcs_q < 4'd2) begin
			root_new = 4'd2;
		end else if (mcs_q > 4'd8) begin
			root_new = 4'd8;
		end else begin
			root_new = mcs_q;
		end
	end

	// the held byte moves to the output register when another byte follows or at the end
	always_comb begin
		emit_v    = 1'b0;
		emit_last = 1'b0;
		emit_done = 1'b0;
		case (state_q)
			S_FL_PAD: begin
				emit_v = held_valid_q && (count_q != '0) && out_free;
			end
			S_PACK: begin
				emit_v = held_valid_q && (bits_q >= gle_pkg::BITS_W'(8)) && out_free;
			end
			S_FINISH: begin
				emit_v    = held_valid_q && out_free;
				emit_last = 1'b1;
				emit_done = last_q;
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ind_q;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = k_q;
		end else if (state_q == S_MISS && nfc_q <= limit && free_q) begin
			ram_we           = 1'b1;
			ram_wdata.used   = 1'b1;
			ram_wdata.code   = nfc_q;
			ram_wdata.prefix = prefix_q;
			ram_wdata.pix    = pix_q;
		end
	end

	gle_probe #(.DICT_SIZE(DICT_SIZE)) u_probe (
		.start      (state_q == S_IDLE),
		.pix        (pix_m),
		.prefix     (prefix_q),
		.ind        (ind_q),
		.stp        (step_q),
		.idx        (probe_idx),
		.first_step (probe_step)
	);

	gle_ram #(.WIDTH(gle_pkg::ENTRY_W), .DEPTH(DICT_SIZE)) u_dict (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ind_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			mcs_q        <= 4'd8;
			root_q       <= 4'd8;
			width_q      <= '0;
			nfc_q        <= '0;
			prefix_q     <= '0;
			last_q       <= 1'b0;
			in_image_q   <= 1'b0;
			partial_q    <= '0;
			count_q      <= '0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			k_q          <= '0;
		end else begin
			if (cfg_we) begin
				mcs_q <= cfg_wdata;
			end
			if (emit_v) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= held_q;
				out_last_q  <= emit_last;
				out_done_q  <= emit_done;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						last_q <= end_of_image;
						k_q    <= '0;
						if (!in_image_q) begin
							pix_q   <= pixel;
							state_q <= S_FIRST;
						end else begin
							pix_q   <= pix_m;
							ind_q   <= probe_idx;
							step_q  <= probe_step;
							state_q <= S_PRB_RD;
						end
					end
				end
				S_FIRST: begin
					root_q     <= root_new;
					nfc_q      <= (gle_pkg::CODE_W'(1) << root_new) + gle_pkg::CODE_W'(2);
					width_q    <= root_new + 4'd1;
					code_q     <= gle_pkg::PREF_W'(1) << root_new;
					prefix_q   <= {4'h0, pix_q & 8'((9'd1 << root_new) - 9'd1)};
					in_image_q <= 1'b1;
					ret_q      <= S_CLEAR;
					state_q    <= S_SEND;
				end
				S_PRB_RD: begin
					state_q <= S_PRB_CMP;
				end
				S_PRB_CMP: begin
					if (!rd_entry.used) begin
						free_q  <= 1'b1;
						state_q <= S_MISS;
					end else if (rd_entry.prefix == prefix_q && rd_entry.pix == pix_q) begin
						prefix_q <= rd_entry.code[gle_pkg::PREF_W-1:0];
						state_q  <= S_LASTCHK;
					end else if (k_q == IDX_W'(DICT_SIZE - 1)) begin
						// chain exhausted with no free slot
						free_q  <= 1'b0;
						state_q <= S_MISS;
					end else begin
						k_q     <= k_q + IDX_W'(1);
						ind_q   <= probe_idx;
						state_q <= S_PRB_RD;
					end
				end
				S_MISS: begin
					if (nfc_q <= limit) begin
						nfc_q <= nfc_q + gle_pkg::CODE_W'(1);
						ovf_q <= (nfc_q + gle_pkg::CODE_W'(1)) > limit;
					end else begin
						ovf_q <= 1'b1;
					end
					code_q  <= prefix_q;
					ret_q   <= S_MISS2;
					state_q <= S_SEND;
				end
				S_MISS2: begin
					prefix_q <= {4'h0, pix_q};
					if (ovf_q && width_q >= 4'(gle_pkg::MAX_WIDTH)) begin
						code_q  <= clr_code[gle_pkg::PREF_W-1:0];
						ret_q   <= S_OVF;
						state_q <= S_SEND;
					end else begin
						if (ovf_q) begin
							width_q <= width_q + 4'd1;
						end
						state_q <= S_LASTCHK;
					end
				end
				S_OVF: begin
					width_q <= root_q + 4'd1;
					nfc_q   <= clr_code + gle_pkg::CODE_W'(2);
					k_q     <= '0;
					state_q <= S_CLEAR;
				end
				S_CLEAR: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == IDX_W'(DICT_SIZE - 1)) begin
						state_q <= S_LASTCHK;
					end
				end
				S_LASTCHK: begin
					if (last_q) begin
						code_q  <= prefix_q;
						ret_q   <= S_FL_END;
						state_q <= S_SEND;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_FL_END: begin
					code_q  <= clr_code[gle_pkg::PREF_W-1:0] + gle_pkg::PREF_W'(1);
					ret_q   <= S_FL_PAD;
					state_q <= S_SEND;
				end
				S_FL_PAD: begin
					if (count_q == '0 || can_push) begin
						if (count_q != '0) begin
							held_q       <= partial_q;
							held_valid_q <= 1'b1;
						end
						partial_q  <= '0;
						count_q    <= '0;
						in_image_q <= 1'b0;
						state_q    <= S_FINISH;
					end
				end
				S_SEND: begin
					acc_q   <= gle_pkg::ACC_W'(partial_q)
						| (gle_pkg::ACC_W'(code_q & width_mask) << count_q);
					bits_q  <= gle_pkg::BITS_W'(count_q) + gle_pkg::BITS_W'(width_q);
					state_q <= S_PACK;
				end
				S_PACK: begin
					if (bits_q >= gle_pkg::BITS_W'(8)) begin
						if (can_push) begin
							held_q       <= acc_q[7:0];
							held_valid_q <= 1'b1;
							acc_q        <= acc_q >> 8;
							bits_q       <= bits_q - gle_pkg::BITS_W'(8);
						end
					end else begin
						partial_q <= acc_q[7:0];
						count_q   <= bits_q[2:0];
						state_q   <= ret_q;
					end
				end
				S_FINISH: begin
					// the byte held back is the last of this transaction
					if (!held_valid_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						held_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: design/gle_checker.sv
`default_nettype none
`include "gif_lzw_encoder_defines.svh"
module gle_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] stream_byte,
	input wire logic       run_last,
	input wire logic       image_done
);
	// the end of an image is always the end of a transaction's bytes
	`GLE_ASSERT_SAME(a_done_last, out_valid && image_done, run_last)
	// the encoder is busy right after taking a pixel
	`GLE_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
	`GLE_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid)
	`GLE_ASSERT_NEXT(a_hold_byte, out_valid && !out_ready, $stable(stream_byte))
endmodule

bind gif_lzw_encoder gle_checker u_gle_checker (.*);
`default_nettype wire

FILE: tb/gif_lzw_encoder_tb.sv
`timescale 1ns / 100ps
module gif_lzw_encoder_tb;
	localparam int DICT = 5021;
	localparam longint CYCLE_LIMIT = 5000000;
	localparam int SETTLE = 64;

	typedef struct {
		logic [7:0] stream_byte;
		logic       run_last;
		logic       image_done;
	} lzw_byte_t;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_ready;
	logic [7:0] pixel = 0;
	logic       end_of_image = 0;
	logic       out_valid;
	logic       out_ready = 0;
	logic [7:0] stream_byte;
	logic       run_last;
	logic       image_done;
	logic       cfg_we = 0;
	logic [3:0] cfg_wdata = 0;

	gif_lzw_encoder #(.DICT_SIZE(DICT)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pixel(pixel), .end_of_image(end_of_image),
		.out_valid(out_valid), .out_ready(out_ready),
		.stream_byte(stream_byte), .run_last(run_last), .image_done(image_done),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	longint cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// predicted encoder state
	bit          dict_used [DICT];
	logic [12:0] dict_code [DICT];
	logic [11:0] dict_prefix [DICT];
	logic [7:0]  dict_pix [DICT];
	logic [3:0]  min_size = 4'd8;
	logic [11:0] prefix_code;
	logic [12:0] next_code;
	logic [3:0]  code_width;
	logic [7:0]  partial_byte;
	logic [2:0]  partial_count;
	logic        in_image;
	logic [3:0]  root_bits;

	lzw_byte_t pending_bytes[$];
	lzw_byte_t step_bytes[$];
	int errors = 0;
	bit no_idle = 0;

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	task automatic reset_encoder_model();
		prefix_code = 0;
		next_code = 0;
		code_width = 0;
		partial_byte = 0;
		partial_count = 0;
		in_image = 0;
		root_bits = 8;
		foreach (dict_used[i]) dict_used[i] = 0;
	endtask

	task automatic pack_code(int unsigned c);
		int unsigned w;
		int unsigned acc;
		int unsigned bits;
		lzw_byte_t b;
		w = code_width;
		if (w > 12) w = 12;
		c &= (1 << w) - 1;
		acc = partial_byte | (c << partial_count);
		bits = partial_count + w;
		while (bits >= 8) begin
			b.stream_byte = acc[7:0];
			b.run_last = 0;
			b.image_done = 0;
			step_bytes.insert(step_bytes.size(), b);
			acc >>= 8;
			bits -= 8;
		end
		partial_byte = acc[7:0];
		partial_count = bits[2:0];
	endtask

	// 1 pair found, 0 free slot, -1 neither
	function automatic int probe_dict(int unsigned parent, int unsigned pix,
		output int unsigned slot);
		int unsigned ind;
		int unsigned stp;
		ind = ((pix << 4) ^ parent) % DICT;
		stp = (ind == 0) ? 1 : DICT - ind;
		slot = 0;
		for (int k = 0; k < DICT; k++) begin
			if (!dict_used[ind]) begin
				slot = ind;
				return 0;
			end
			if (dict_prefix[ind] == parent && dict_pix[ind] == pix) begin
				slot = ind;
				return 1;
			end
			if (ind >= stp) ind -= stp;
			else ind = ind + DICT - stp;
		end
		return -1;
	endfunction

	task automatic encode_pixel(logic [7:0] pin, logic last);
		int unsigned b;
		int unsigned clr;
		int unsigned pix;
		int unsigned slot;
		int unsigned lim;
		int r;
		lzw_byte_t e;
		step_bytes.delete();
		if (!in_image) begin
			b = min_size;
			if (b < 2) b = 2;
			if (b > 8) b = 8;
			root_bits = 4'(b);
			foreach (dict_used[i]) dict_used[i] = 0;
			next_code = 13'((1 << b) + 2);
			code_width = 4'(b + 1);
			pack_code(1 << b);
			prefix_code = 12'(pin & ((1 << b) - 1));
			in_image = 1;
		end else begin
			clr = 1 << root_bits;
			pix = pin & (clr - 1);
			r = probe_dict(prefix_code, pix, slot);
			if (r == 1) begin
				prefix_code = dict_code[slot][11:0];
			end else begin
				lim = 1 << code_width;
				if (next_code <= lim) begin
					if (r == 0) begin
						dict_used[slot] = 1;
						dict_code[slot] = next_code;
						dict_prefix[slot] = prefix_code;
						dict_pix[slot] = 8'(pix);
					end
					next_code++;
				end
				pack_code(prefix_code);
				prefix_code = 12'(pix);
				if (next_code > lim) begin
					if (code_width >= 12) begin
						pack_code(clr);
						foreach (dict_used[i]) dict_used[i] = 0;
						code_width = root_bits;
						next_code = 13'(clr + 2);
					end
					code_width++;
				end
			end
		end
		if (last) begin
			clr = 1 << root_bits;
			pack_code(prefix_code);
			pack_code(clr + 1);
			if (partial_count != 0) begin
				e.stream_byte = partial_byte;
				e.run_last = 0;
				e.image_done = 0;
				step_bytes.insert(step_bytes.size(), e);
			end
			partial_byte = 0;
			partial_count = 0;
			in_image = 0;
		end
		if (step_bytes.size() > 10) step_bytes = step_bytes[0:9];
		if (step_bytes.size() > 0) begin
			step_bytes[$].run_last = 1;
			if (last) step_bytes[$].image_done = 1;
		end
		foreach (step_bytes[i]) pending_bytes.insert(pending_bytes.size(), step_bytes[i]);
	endtask

	// one pixel transaction; valid is left high for a back-to-back follow-up
	task automatic send_pixel(logic [7:0] p, logic last);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1;
		pixel <= p;
		end_of_image <= last;
		do @(posedge clk); while (!in_ready);
		encode_pixel(p, last);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_min_size(logic [3:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		min_size = v;
	endtask

	task automatic send_image(int len, int alphabet);
		for (int i = 0; i < len; i++)
			send_pixel(8'(alphabet >= 256 ? $urandom_range(0, 255)
				: $urandom_range(0, alphabet - 1)), i == len - 1);
	endtask

	// byte side: random stalls, each result checked against the oldest prediction
	initial begin
		int stall;
		lzw_byte_t want;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 11);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 0;
			end
			@(negedge clk);
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			if (pending_bytes.size() == 0) begin
				report_mismatch("unexpected byte", stream_byte, -1);
			end else begin
				want = pending_bytes.pop_front();
				if (stream_byte !== want.stream_byte)
					report_mismatch("stream_byte", stream_byte, want.stream_byte);
				if (run_last !== want.run_last)
					report_mismatch("run_last", run_last, want.run_last);
				if (image_done !== want.image_done)
					report_mismatch("image_done", image_done, want.image_done);
			end
		end
	end

	task automatic test_default_size();
		send_pixel(8'd0, 0);
		send_pixel(8'd255, 0);
		send_pixel(8'd0, 0);
		send_pixel(8'd0, 0);
		send_pixel(8'd255, 0);
		send_pixel(8'd255, 1);
		send_pixel(8'd7, 1); // single-pixel image
		drop_valid();
	endtask

	task automatic test_small_size();
		write_min_size(4'd2);
		// high bits masked off
		send_pixel(8'hff, 0);
		send_pixel(8'h03, 0);
		send_pixel(8'hfc, 0);
		send_pixel(8'h01, 0);
		send_pixel(8'h03, 0);
		send_pixel(8'h03, 1);
		drop_valid();
	endtask

	task automatic test_clamped_sizes();
		write_min_size(4'd0);
		send_pixel(8'h05, 0);
		send_pixel(8'h02, 1);
		drop_valid();
		write_min_size(4'd15);
		send_pixel(8'hab, 0);
		send_pixel(8'h54, 1);
		drop_valid();
		write_min_size(4'd1);
		send_pixel(8'h01, 1);
		drop_valid();
	endtask

	task automatic test_random_images();
		int sent;
		int len;
		int alpha;
		bit paused;
		sent = 0;
		paused = 0;
		while (sent < 140) begin
			write_min_size(4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
				: $urandom_range(2, 8)));
			no_idle = ($urandom_range(0, 4) == 0);
			len = $urandom_range(1, 40);
			alpha = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : 256;
			for (int i = 0; i < len; i++) begin
				if (!paused && sent > 100) begin
					// hold the sender back until the output has caught up
					drop_valid();
					while (pending_bytes.size() != 0) @(posedge clk);
					paused = 1;
				end
				send_pixel(8'(alpha >= 256 ? $urandom_range(0, 255)
					: $urandom_range(0, alpha - 1)), i == len - 1);
				sent++;
			end
			drop_valid();
		end
		no_idle = 0;
	endtask

	task automatic test_code_growth();
		write_min_size(4'd2);
		no_idle = 1;
		send_image(60, 4);
		drop_valid();
		no_idle = 0;
	endtask

	initial begin
		reset_encoder_model();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		test_default_size();
		test_small_size();
		test_clamped_sizes();
		test_random_images();
		test_code_growth();
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_bytes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+design
design/gle_pkg.sv
design/gle_ram.sv
design/gle_probe.sv
design/gif_lzw_encoder.sv
design/gle_checker.sv
tb/gif_lzw_encoder_tb.sv
